@@ rtl/core/overwrite_oldest_ring_queue_assert.svh @@
// assertion macros used by the ring queue checker
`ifndef OVERWRITE_OLDEST_RING_QUEUE_ASSERT_SVH
`define OVERWRITE_OLDEST_RING_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define OOQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ring queue assertion failed");

// next-cycle implication, disabled while reset is low
`define OOQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ring queue assertion failed");

`endif

@@ rtl/core/ooq_pkg.sv @@
// types, constants and helpers of the overwriting ring queue
`timescale 1ns / 1ps
package ooq_pkg;

  localparam int Depth    = 16;
  localparam int WordBits = 64;
  localparam int PtrW     = $clog2(Depth);
  localparam int OpW      = 2;
  localparam int PayW     = 64;
  localparam int OccW     = 5;

  typedef logic [PtrW-1:0]     ptr_t;
  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [OpW-1:0] {
    OpPush   = 2'd0,
    OpPull   = 2'd1,
    OpStatus = 2'd2
  } opcode_e;

  // pointer increment with wrap at the last slot
  function automatic ptr_t ptr_adv(input ptr_t p);
    ptr_t r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ooq_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module ooq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/overwrite_oldest_ring_queue.sv @@
// overwriting ring queue: top level with slot memory and pointer logic
// an accepted command's result is registered and shown in the cycle after it, with done_o high
// throughput: one command per cycle; busy is low except for the first cycle after reset
// the slot memory's registered read sets the single result stage
// reset clears both pointers and the holds-data flag; slots hold garbage until pushed
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps
module overwrite_oldest_ring_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ooq_pkg::OpW-1:0]   opcode_i,
  input  logic [ooq_pkg::PayW-1:0]  push_word_i,
  output logic                      done_o,
  output logic [ooq_pkg::PayW-1:0]  pull_word_o,
  output logic                      pull_hit_o,
  output logic                      dropped_oldest_o,
  output logic [ooq_pkg::OccW-1:0]  occupancy_o
);

  import ooq_pkg::*;

  // pointer state
  ptr_t wr_ptr_q, wr_ptr_d;
  ptr_t rd_ptr_q, rd_ptr_d;
  logic hold_q, hold_d;

  // result stage
  logic            done_q, hit_q, drop_q;
  logic            hit_d, drop_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic            busy_q;

  // memory side
  logic  mem_we, mem_re;
  word_t mem_rdata;

  logic       accept;
  logic [PtrW:0] diff;

  assign accept = start && !busy_q;

  // command decode and next pointer state
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    hold_d   = hold_q;
    hit_d    = 1'b0;
    drop_d   = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    if (accept) begin
      case (opcode_e'(opcode_i))
        OpPush: begin
          // full queue: oldest entry is overwritten, read pointer follows
          if (hold_q && (wr_ptr_q == rd_ptr_q)) begin
            rd_ptr_d = ptr_adv(rd_ptr_q);
            drop_d   = 1'b1;
          end
          wr_ptr_d = ptr_adv(wr_ptr_q);
          hold_d   = 1'b1;
          mem_we   = 1'b1;
        end
        OpPull: begin
          // empty queue: nothing read, state unchanged
          if (hold_q || (wr_ptr_q != rd_ptr_q)) begin
            hit_d    = 1'b1;
            mem_re   = 1'b1;
            rd_ptr_d = ptr_adv(rd_ptr_q);
            if (wr_ptr_q == ptr_adv(rd_ptr_q)) begin
              hold_d = 1'b0;
            end
          end
        end
        default: begin
          // status query and unused code change nothing
        end
      endcase
    end
  end

  // occupancy after the command, from the next pointers
  always_comb begin
    diff = {1'b0, wr_ptr_d} - {1'b0, rd_ptr_d};
    if (wr_ptr_d == rd_ptr_d) begin
      occ_d = hold_d ? OccW'(Depth) : '0;
    end else if (wr_ptr_d > rd_ptr_d) begin
      occ_d = OccW'(diff);
    end else begin
      occ_d = OccW'((PtrW + 1)'(Depth) + diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      hold_q   <= 1'b0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      drop_q   <= 1'b0;
      occ_q    <= '0;
      busy_q   <= 1'b1;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      hold_q   <= hold_d;
      done_q   <= accept;
      hit_q    <= hit_d;
      drop_q   <= drop_d;
      busy_q   <= 1'b0;
      if (accept) begin
        occ_q <= occ_d;
      end
    end
  end

  // slot memory: push writes at the write pointer, pull reads at the read pointer
  ooq_ram #(
    .Width (WordBits),
    .Depth (Depth)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (push_word_i[WordBits-1:0]),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  assign busy             = busy_q;
  assign done_o           = done_q;
  assign pull_hit_o       = hit_q;
  assign dropped_oldest_o = drop_q;
  assign occupancy_o      = occ_q;
  // pulled beat comes straight from the ram output register
  assign pull_word_o      = hit_q ? PayW'(mem_rdata) : '0;

endmodule

@@ rtl/core/ooq_checker.sv @@
// port-level checker of the overwriting ring queue and its bind
`timescale 1ns / 1ps
`include "overwrite_oldest_ring_queue_assert.svh"
module ooq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic                      pull_hit_o,
  input logic                      dropped_oldest_o,
  input logic [ooq_pkg::OccW-1:0]  occupancy_o
);

  import ooq_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // one result beat for every accepted command, none otherwise
  `OOQ_ASSERT_NEXT(a_done_follows, accept, done_o)
  `OOQ_ASSERT_NEXT(a_no_spurious_done, !accept, !done_o)
  // a drop only happens on a push into a full queue, which stays full
  `OOQ_ASSERT_IMPL(a_drop_full, dropped_oldest_o, done_o && occupancy_o == OccW'(Depth))
  // a pull that hit leaves at least one free slot and cannot have dropped
  `OOQ_ASSERT_IMPL(a_hit_frees, pull_hit_o,
                   done_o && !dropped_oldest_o && occupancy_o < OccW'(Depth))

endmodule

bind overwrite_oldest_ring_queue ooq_checker u_ooq_checker (.*);
